FILE: rtl/ogi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ogi_pkg
// Shared sizes, register indexes and types for the occupancy grid inflater.
// ----------------------------------------------------------------------------
package ogi_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RADIUS = 7;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WID_W   = 11;
  localparam int HGT_W   = 16;
  localparam int ROW_W   = HGT_W + 1;
  localparam int T_W     = 27;
  localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
  localparam int HIST_W  = 2 * MAX_RADIUS;
  localparam int WIN     = 2 * MAX_RADIUS + 1;
  localparam int LAG_W   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int VDEPTH  = 1 << LAG_W;
  localparam int CELL_W  = 8;
  localparam int CFG_W   = 16;

  localparam logic signed [CELL_W-1:0] OBSTACLE = 8'sd100;

  typedef enum logic [1:0] {
    REG_ROBOT  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } ogi_reg_t;

  // column-wise OR of the vertical window: full span and span without end rows
  typedef struct packed {
    logic full;
    logic inner;
  } ogi_vert_t;

  typedef struct packed {
    logic shift;
    logic use_inner;
    logic mask;
  } ogi_cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/ogi_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ogi_cell
// One column slot of the horizontal window: holds a vertical OR pair, passes
// it to the next slot on each beat and reports its masked hit term.
// ----------------------------------------------------------------------------
module ogi_cell (
  input  wire                          clk,
  input  wire ogi_pkg::ogi_cell_ctrl_t ctrl,
  input  wire ogi_pkg::ogi_vert_t      vert_in,
  output ogi_pkg::ogi_vert_t           vert_out,
  output logic                         hit
);

  ogi_pkg::ogi_vert_t vert_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      vert_r <= vert_in;
    end
  end

  assign vert_out = vert_r;
  assign hit      = ctrl.mask & (ctrl.use_inner ? vert_r.inner : vert_r.full);

endmodule
`default_nettype wire

FILE: rtl/occupancy_grid_inflate_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// occupancy_grid_inflate_core
// Streaming obstacle inflation over a raster occupancy grid.
// Output: a result is registered in stage 1 and in the output register after
//   the beat that completes its window, which is radius*width+radius beats
//   after its own cell. Throughput: one beat per cycle when not stalled; each
//   beat does one column-history read and write and one delay-line read.
// Reset: synchronous active-low; counters and config to defaults, no memory
//   clearing pass. Input is held off in the cycle after each config write.
// ----------------------------------------------------------------------------
module occupancy_grid_inflate_core (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [ogi_pkg::CELL_W-1:0]     in_tdata,   // [7:0] cell_in
  input  wire                            in_tuser,   // [0] is_flush
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [ogi_pkg::CELL_W-1:0]     out_tdata,  // [7:0] cell_out
  output logic                           out_tuser,  // [0] was_inflated
  output logic                           out_tlast,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [1:0]                     cfg_index,
  input  wire  [ogi_pkg::CFG_W-1:0]      cfg_data
);

  localparam int COL_W  = ogi_pkg::COL_W;
  localparam int WID_W  = ogi_pkg::WID_W;
  localparam int HGT_W  = ogi_pkg::HGT_W;
  localparam int ROW_W  = ogi_pkg::ROW_W;
  localparam int T_W    = ogi_pkg::T_W;
  localparam int RAD_W  = ogi_pkg::RAD_W;
  localparam int HIST_W = ogi_pkg::HIST_W;
  localparam int WIN    = ogi_pkg::WIN;
  localparam int LAG_W  = ogi_pkg::LAG_W;
  localparam int CELL_W = ogi_pkg::CELL_W;
  localparam int SPAN_W = RAD_W + 1;
  localparam int CPOS_W = COL_W + 2;
  localparam logic [WID_W-1:0] MAX_W_C = WID_W'(ogi_pkg::MAX_WIDTH);
  localparam logic [3:0] MAX_RAD_C = 4'(ogi_pkg::MAX_RADIUS);

  // config
  logic [3:0]       robot_r;
  logic [WID_W-1:0] gw_r;
  logic [HGT_W-1:0] gh_r;
  logic             cfg_hold_r;
  logic             cfg_wr;
  logic             abort;

  // derived config
  logic [WID_W-1:0] w_c, w_r;
  logic [HGT_W-1:0] h_c, h_r;
  logic [RAD_W-1:0] rad_c, rad_r;
  logic             pass_c, pass_r, corner_r;
  logic [LAG_W-1:0] lag_r;
  logic [T_W-1:0]   total_r;

  // raster counters
  logic [T_W-1:0]   t_r;
  logic [COL_W-1:0] col_r, ec_r;
  logic [ROW_W-1:0] row_r;
  logic [HGT_W-1:0] er_r;

  logic             accept, in_grid, emit, last;
  logic             occ;
  logic [CELL_W-1:0] cell_w;
  logic [WIN-1:0]   rmask, cmask;
  logic [CPOS_W-1:0] cpos;
  logic [SPAN_W-1:0] span;

  // stage 1
  logic              s1_valid_r, s1_emit_r, s1_last_r, s1_occ_r, s1_fwd_r;
  logic [CELL_W-1:0] s1_cell_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [WIN-1:0]    s1_rmask_r, s1_cmask_r;
  logic              s1_go, advance;

  // memories
  logic [CELL_W-1:0] vmem [ogi_pkg::VDEPTH];
  logic [HIST_W-1:0] hmem [ogi_pkg::MAX_WIDTH];
  logic [CELL_W-1:0] vrd_r;
  logic [HIST_W-1:0] hrd_r, fwd_data_r;
  logic [LAG_W-1:0]  waddr, raddr;

  logic [HIST_W-1:0] hist, hist_new;
  logic [WIN-1:0]    vbits;
  ogi_pkg::ogi_vert_t vert_new;
  ogi_pkg::ogi_vert_t chain_out [HIST_W];
  ogi_pkg::ogi_cell_ctrl_t cctrl [HIST_W];
  logic [HIST_W-1:0] cell_hit;
  logic              term0, hit;
  logic [CELL_W-1:0] v;

  logic              out_valid_r, out_user_r, out_last_r;
  logic [CELL_W-1:0] out_data_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;
  assign abort     = cfg_wr && (cfg_index == ogi_pkg::REG_ROBOT ||
                                cfg_index == ogi_pkg::REG_WIDTH ||
                                cfg_index == ogi_pkg::REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      robot_r    <= '0;
      gw_r       <= MAX_W_C;
      gh_r       <= HGT_W'(1);
      cfg_hold_r <= 1'b0;
    end else begin
      cfg_hold_r <= cfg_wr;
      if (cfg_wr) begin
        case (cfg_index)
          ogi_pkg::REG_ROBOT:  robot_r <= cfg_data[3:0];
          ogi_pkg::REG_WIDTH:  gw_r    <= cfg_data[WID_W-1:0];
          ogi_pkg::REG_HEIGHT: gh_r    <= cfg_data[HGT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (gw_r == '0)          w_c = WID_W'(1);
    else if (gw_r > MAX_W_C) w_c = MAX_W_C;
    else                     w_c = gw_r;
    h_c    = (gh_r == '0) ? HGT_W'(1) : gh_r;
    pass_c = robot_r <= 4'd1;
    rad_c  = pass_c ? '0 : (((robot_r >> 1) > MAX_RAD_C) ? RAD_W'(MAX_RAD_C) :
                            RAD_W'(robot_r >> 1));
  end

  // config is static while items flow; held input covers the update cycle
  always_ff @(posedge clk) begin
    w_r      <= w_c;
    h_r      <= h_c;
    rad_r    <= rad_c;
    pass_r   <= pass_c;
    corner_r <= ~robot_r[0];
    lag_r    <= LAG_W'(T_W'(rad_c) * T_W'(w_c) + T_W'(rad_c));
    total_r  <= T_W'(w_c) * T_W'(h_c);
  end

  assign advance   = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (advance || !s1_emit_r);
  assign in_tready = !cfg_hold_r && (!s1_valid_r || s1_go);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    in_grid = t_r < total_r;
    emit    = t_r >= T_W'(lag_r);
    last    = emit && (er_r == h_r - HGT_W'(1)) && (ec_r == COL_W'(w_r - WID_W'(1)));
    occ     = in_grid && !in_tuser && ($signed(in_tdata) > 8'sd0);
    cell_w  = (in_grid && !in_tuser) ? in_tdata : '0;
    span    = {rad_r, 1'b0};
    cpos    = CPOS_W'(ec_r) + CPOS_W'(rad_r);
    for (int k = 0; k < WIN; k++) begin
      rmask[k] = (ROW_W'(k) <= row_r) && (SPAN_W'(k) <= span);
      cmask[k] = (SPAN_W'(k) <= span) && (cpos >= CPOS_W'(k)) &&
                 ((cpos - CPOS_W'(k)) < CPOS_W'(w_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || abort) begin
      t_r   <= '0;
      col_r <= '0;
      row_r <= '0;
      ec_r  <= '0;
      er_r  <= '0;
    end else if (accept) begin
      if (last) begin
        t_r   <= '0;
        col_r <= '0;
        row_r <= '0;
        ec_r  <= '0;
        er_r  <= '0;
      end else begin
        t_r <= t_r + T_W'(1);
        if (col_r == COL_W'(w_r - WID_W'(1))) begin
          col_r <= '0;
          row_r <= row_r + ROW_W'(1);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
        if (emit) begin
          if (ec_r == COL_W'(w_r - WID_W'(1))) begin
            ec_r <= '0;
            er_r <= er_r + HGT_W'(1);
          end else begin
            ec_r <= ec_r + COL_W'(1);
          end
        end
      end
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_fwd_r   <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        s1_fwd_r   <= s1_go && (col_r == s1_col_r);
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
        s1_fwd_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit_r  <= emit;
      s1_last_r  <= last;
      s1_occ_r   <= occ;
      s1_cell_r  <= cell_w;
      s1_col_r   <= col_r;
      s1_rmask_r <= rmask;
      s1_cmask_r <= cmask;
    end
    if (s1_go) begin
      fwd_data_r <= hist_new;
    end
  end

  // center-value delay line and per-column row history
  assign waddr = t_r[LAG_W-1:0];
  assign raddr = LAG_W'(t_r - T_W'(lag_r));

  always_ff @(posedge clk) begin
    if (accept) begin
      vmem[waddr] <= cell_w;
      vrd_r       <= vmem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      hmem[s1_col_r] <= hist_new;
    end
    if (accept) begin
      hrd_r <= hmem[col_r];
    end
  end

  // vertical OR; bit k is the row k above the newest one
  always_comb begin
    hist     = s1_fwd_r ? fwd_data_r : hrd_r;
    hist_new = {hist[HIST_W-2:0], s1_occ_r};
    vbits    = {hist, s1_occ_r} & s1_rmask_r;
    vert_new.full  = |vbits;
    vert_new.inner = 1'b0;
    for (int k = 1; k < WIN; k++) begin
      if (SPAN_W'(k) != span) vert_new.inner = vert_new.inner | vbits[k];
    end
    term0 = s1_cmask_r[0] & ((corner_r && span != '0) ? vert_new.inner : vert_new.full);
  end

  always_comb begin
    for (int i = 0; i < HIST_W; i++) begin
      cctrl[i].shift     = s1_go;
      cctrl[i].mask      = s1_cmask_r[i+1];
      cctrl[i].use_inner = corner_r && (SPAN_W'(i + 1) == span);
    end
  end

  for (genvar i = 0; i < HIST_W; i++) begin : g_chain
    ogi_cell u_cell (
      .clk      (clk),
      .ctrl     (cctrl[i]),
      .vert_in  ((i == 0) ? vert_new : chain_out[(i == 0) ? 0 : i - 1]),
      .vert_out (chain_out[i]),
      .hit      (cell_hit[i])
    );
  end

  assign hit = !pass_r && (term0 || (|cell_hit));
  assign v   = pass_r ? s1_cell_r : vrd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit_r) begin
      out_data_r <= hit ? ogi_pkg::OBSTACLE : v;
      out_user_r <= hit && (v != ogi_pkg::OBSTACLE);
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_inflate_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == ogi_pkg::OBSTACLE)
    else $error("inflated beat without obstacle value");
  a_fwd_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fwd_r |-> s1_valid_r)
    else $error("history forward without stage 1 item");
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && !cfg_hold_r |-> s1_valid_r && !s1_go)
    else $error("input stalled with free stage 1");
`endif

endmodule
`default_nettype wire
